### rtl/hashed_key_value_table_defines.svh
// Assertion macros used by the checker file.
`ifndef HASHED_KEY_VALUE_TABLE_DEFINES_SVH
`define HASHED_KEY_VALUE_TABLE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define HKV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define HKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/hkvt_pkg.sv
// Shared types and constants of the hashed key-value table.
package hkvt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic CFG_KEY_BYTES    = 1'b0;
  localparam logic CFG_BUCKET_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] value_out;
    logic [6:0]  entry_count;
  } out_word_t;

  // Front-end states: hash the key bytes, reduce the sum, then push the word.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_HASH,
    FS_MOD,
    FS_PUSH
  } front_state_e;

  // Back-end states: scan the bucket ways, then commit and deliver.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_COMMIT,
    BS_OUT
  } back_state_e;

endpackage

### rtl/hkvt_front.sv
// Front end: accepts a word, hashes the key bytes and reduces modulo the bucket count.
module hkvt_front #(
  parameter int BUCKETS   = 16,
  parameter int KEY_BYTES = 8,
  parameter int BW        = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  hkvt_pkg::in_word_t in_word_i,
  input  logic [3:0]        key_bytes_i,
  input  logic [4:0]        bucket_count_i,
  output logic              q_valid_o,
  input  logic              q_full_i,
  output hkvt_pkg::in_word_t q_word_o,
  output logic [BW-1:0]     q_bucket_o,
  output logic [63:0]       q_mask_o
);

  // The weighted sum of eight bytes reaches 9180, which needs 14 bits.
  localparam int SUM_W = 14;

  hkvt_pkg::front_state_e state_q, state_d;
  hkvt_pkg::in_word_t word_q;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  nbytes;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [8:0]  mod;
  logic [8:0]  buckets_cap;
  logic [63:0] mask;
  logic [22:0] mod_sh;

  // Effective byte count and bucket count, clamped.
  always_comb begin
    nbytes = key_bytes_i;
    if (nbytes == 4'd0) nbytes = 4'd1;
    if (nbytes > 4'(KEY_BYTES)) nbytes = 4'(KEY_BYTES);
    buckets_cap = 9'(BUCKETS);
    mod = {4'd0, bucket_count_i};
    if (mod == 9'd0) mod = 9'd1;
    if (mod > buckets_cap) mod = buckets_cap;
  end

  // Byte mask over the compared key bytes.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (4'(b) < nbytes) ? 8'hFF : 8'h00;
    end
  end

  // Divisor aligned to the current remainder bit.
  assign mod_sh = {14'd0, mod} << idx_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hkvt_pkg::FS_IDLE: if (in_valid) state_d = hkvt_pkg::FS_HASH;
      hkvt_pkg::FS_HASH: if (idx_q + 4'd1 >= nbytes) state_d = hkvt_pkg::FS_MOD;
      hkvt_pkg::FS_MOD:  if (idx_q == 4'd0) state_d = hkvt_pkg::FS_PUSH;
      hkvt_pkg::FS_PUSH: if (!q_full_i) state_d = hkvt_pkg::FS_IDLE;
      default:           state_d = hkvt_pkg::FS_IDLE;
    endcase
  end

  // Datapath: one weighted byte per cycle, then one remainder bit per cycle.
  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    unique case (state_q)
      hkvt_pkg::FS_IDLE: begin
        idx_d = 4'd0;
        sum_d = '0;
      end
      hkvt_pkg::FS_HASH: begin
        sum_d = sum_q + SUM_W'(word_q.key[idx_q[2:0]*8 +: 8]) *
                SUM_W'({1'b0, idx_q} + 5'd1);
        idx_d = (idx_q + 4'd1 >= nbytes) ? 4'(SUM_W - 1) : idx_q + 4'd1;
      end
      hkvt_pkg::FS_MOD: begin
        if ({9'd0, sum_q} >= mod_sh) sum_d = sum_q - mod_sh[SUM_W-1:0];
        if (idx_q != 4'd0) idx_d = idx_q - 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hkvt_pkg::FS_IDLE;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hkvt_pkg::FS_IDLE && in_valid) word_q <= in_word_i;
  end

  assign in_stall   = (state_q != hkvt_pkg::FS_IDLE);
  assign q_valid_o  = (state_q == hkvt_pkg::FS_PUSH);
  assign q_word_o   = word_q;
  assign q_bucket_o = BW'(sum_q);
  assign q_mask_o   = mask;

endmodule

### rtl/hkvt_back.sv
// Back end: scans the bucket ways, updates the table and forms the result word.
module hkvt_back #(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int VALUE_BITS = 32,
  parameter int BW         = 4,
  parameter int WW         = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  hkvt_pkg::in_word_t q_word_i,
  input  logic [BW-1:0]      q_bucket_i,
  input  logic [63:0]        q_mask_i,
  output logic               out_valid,
  input  logic               out_stall,
  output hkvt_pkg::out_word_t out_word_o
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  hkvt_pkg::back_state_e state_q, state_d;
  logic [SLOTS-1:0] valid_q;
  logic [63:0] key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [63:0] rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic rd_vld_q;
  logic [WW:0] way_q, chk_q;
  logic scan_rd;
  logic hit_q, free_q;
  logic [SW-1:0] hit_slot_q, free_slot_q, rd_slot, val_addr;
  logic [SW-1:0] chk_slot_q;
  logic [6:0] count_q;
  hkvt_pkg::out_word_t res_q;
  logic [1:0] status;
  logic [31:0] vout;

  assign rd_slot = SW'(q_bucket_i) * SW'(WAYS) + SW'(way_q);
  assign scan_rd = (state_q == hkvt_pkg::BS_SCAN) && (way_q < (WW+1)'(WAYS));

  // After the last way is checked, the value port fetches the hit slot.
  assign val_addr = (state_q == hkvt_pkg::BS_SCAN && chk_q == (WW+1)'(WAYS) && hit_q) ?
                    hit_slot_q : rd_slot;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hkvt_pkg::BS_IDLE:   if (q_valid_i) state_d = hkvt_pkg::BS_SCAN;
      hkvt_pkg::BS_SCAN:   if (chk_q == (WW+1)'(WAYS)) state_d = hkvt_pkg::BS_COMMIT;
      hkvt_pkg::BS_COMMIT: state_d = hkvt_pkg::BS_OUT;
      hkvt_pkg::BS_OUT:    if (!out_stall) state_d = hkvt_pkg::BS_IDLE;
      default:             state_d = hkvt_pkg::BS_IDLE;
    endcase
  end

  // Memory read port: one way per cycle.
  always_ff @(posedge clk_i) begin
    rd_key_q   <= key_mem[rd_slot];
    rd_val_q   <= val_mem[val_addr];
    chk_slot_q <= rd_slot;
  end

  // Result of the lookup.
  always_comb begin
    status = hkvt_pkg::ST_OK;
    vout   = 32'd0;
    unique case (hkvt_pkg::action_e'(q_word_i.action))
      hkvt_pkg::ACT_INSERT: begin
        if (hit_q) status = hkvt_pkg::ST_DUPLICATE;
        else if (!free_q) status = hkvt_pkg::ST_FULL;
      end
      hkvt_pkg::ACT_REMOVE, hkvt_pkg::ACT_FIND: begin
        if (!hit_q) status = hkvt_pkg::ST_NOT_FOUND;
        else vout = 32'(signed'(rd_val_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hkvt_pkg::BS_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      way_q    <= '0;
      chk_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_rd && valid_q[rd_slot];
      if (state_q == hkvt_pkg::BS_IDLE) begin
        way_q  <= '0;
        chk_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (state_q == hkvt_pkg::BS_SCAN) begin
        if (scan_rd) way_q <= way_q + 1'b1;
        if (way_q != '0 && chk_q != (WW+1)'(WAYS)) begin
          chk_q <= chk_q + 1'b1;
          if (rd_vld_q) begin
            if (!hit_q && ((rd_key_q ^ q_word_i.key) & q_mask_i) == 64'd0) begin
              hit_q      <= 1'b1;
              hit_slot_q <= chk_slot_q;
            end
          end else if (!free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= chk_slot_q;
          end
        end
      end
      if (state_q == hkvt_pkg::BS_COMMIT) begin
        if (q_word_i.action == hkvt_pkg::ACT_INSERT && !hit_q && free_q) begin
          valid_q[free_slot_q] <= 1'b1;
          count_q <= count_q + 7'd1;
        end else if (q_word_i.action == hkvt_pkg::ACT_REMOVE && hit_q) begin
          valid_q[hit_slot_q] <= 1'b0;
          count_q <= count_q - 7'd1;
        end
      end
    end
  end

  // Capture the result and store the new entry on insert.
  always_ff @(posedge clk_i) begin
    if (state_q == hkvt_pkg::BS_COMMIT) begin
      res_q.status    <= status;
      res_q.value_out <= vout;
      if (q_word_i.action == hkvt_pkg::ACT_INSERT && !hit_q && free_q) begin
        key_mem[free_slot_q] <= q_word_i.key;
        val_mem[free_slot_q] <= VALUE_BITS'(q_word_i.value);
      end
    end
  end

  assign q_pop_o    = (state_q == hkvt_pkg::BS_OUT) && !out_stall;
  assign out_valid  = (state_q == hkvt_pkg::BS_OUT);
  assign out_word_o = '{status: res_q.status, value_out: res_q.value_out,
                        entry_count: count_q};

endmodule

### rtl/hkvt_queue.sv
// Two-entry queue between the front end and the back end.
module hkvt_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && valid_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= push_data_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

endmodule

### rtl/hashed_key_value_table.sv
// Top level of the hashed key-value table.
// Usage: one input word carries an action (insert, remove, find), a 64-bit key
// and a 32-bit value. in_valid with in_stall low accepts it. Each word gives
// exactly one result word on out_valid: a status, the found or removed value,
// and the entry count after the action.
// The front end hashes the key bytes (one to eight), reduces the sum by
// shift-and-subtract remainder and pushes the word into the queue. The back
// end reads one bucket way per cycle from the slot memory, commits and
// presents the result. The front end can accept a new word and work on it
// while the back end still handles the previous one.
// Reset clears all valid bits and the entry count; the configuration returns
// to one key byte and sixteen buckets. Key and value memories are not cleared.
// When the receiver stalls, the result word holds, the back end waits, the
// queue fills and the input then stalls in turn.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i.
module hashed_key_value_table #(
  parameter int BUCKETS    = 16,
  parameter int WAYS       = 4,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  hkvt_pkg::in_word_t  in_word_i,
  output logic                out_valid,
  input  logic                out_stall,
  output hkvt_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int QW = $bits(hkvt_pkg::in_word_t) + BW + 64;

  logic [3:0] key_bytes_q;
  logic [4:0] bucket_count_q;
  logic f_valid, q_full, q_valid, q_pop;
  hkvt_pkg::in_word_t f_word, q_word;
  logic [BW-1:0] f_bucket, q_bucket;
  logic [63:0] f_mask, q_mask;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q    <= 4'd1;
      bucket_count_q <= 5'd16;
    end else if (cfg_we_i) begin
      if (cfg_index_i == hkvt_pkg::CFG_KEY_BYTES) key_bytes_q <= cfg_data_i[3:0];
      else bucket_count_q <= cfg_data_i;
    end
  end

  hkvt_front #(.BUCKETS(BUCKETS), .KEY_BYTES(KEY_BYTES), .BW(BW)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_word_i,
    .key_bytes_i(key_bytes_q), .bucket_count_i(bucket_count_q),
    .q_valid_o(f_valid), .q_full_i(q_full), .q_word_o(f_word),
    .q_bucket_o(f_bucket), .q_mask_o(f_mask)
  );

  hkvt_queue #(.DW(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .push_data_i({f_word, f_bucket, f_mask}),
    .full_o(q_full), .pop_i(q_pop), .valid_o(q_valid),
    .data_o({q_word, q_bucket, q_mask})
  );

  hkvt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .VALUE_BITS(VALUE_BITS), .BW(BW),
              .WW(WW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .q_bucket_i(q_bucket), .q_mask_i(q_mask), .out_valid, .out_stall, .out_word_o
  );

endmodule

### rtl/hkvt_checker.sv
// Port-level checker for the hashed key-value table, with its bind.
`include "hashed_key_value_table_defines.svh"
module hkvt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hkvt_pkg::out_word_t out_word_o
);

  // A stalled result word holds.
  `HKV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(out_word_o), "result changed under stall")
  // The entry count never exceeds the table size.
  `HKV_ASSERT_IMP(a_count_max, clk_i, rst_ni, out_valid, out_word_o.entry_count <= 7'd64, "entry count too large")
  // A not-found result never carries a nonzero value.
  `HKV_ASSERT_IMP(a_nf_zero, clk_i, rst_ni, out_valid && out_word_o.status == hkvt_pkg::ST_NOT_FOUND, out_word_o.value_out == 32'sd0, "not found with value")

endmodule

bind hashed_key_value_table hkvt_checker u_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_word_o
);

### tb/tb_hashed_key_value_table.sv
// Self-checking testbench for the hashed key-value table.
`timescale 1ns / 1ps

module tb_hashed_key_value_table;

  localparam int NBUCKETS = 16;
  localparam int NWAYS = 4;
  localparam int NSLOTS = NBUCKETS * NWAYS;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hkvt_pkg::in_word_t in_word_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hkvt_pkg::out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  hashed_key_value_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_word_i(in_word_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the table contents and settings.
  logic        mir_valid [NSLOTS];
  logic [63:0] mir_key [NSLOTS];
  logic [31:0] mir_value [NSLOTS];
  int          mir_held;
  logic [3:0]  mir_key_bytes;
  logic [4:0]  mir_buckets;

  hkvt_pkg::out_word_t pending_results[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [63:0] key_pool[24];

  // Works out one table action and updates the mirror.
  function automatic hkvt_pkg::out_word_t table_lookup(hkvt_pkg::in_word_t w);
    hkvt_pkg::out_word_t r;
    int nbytes, nbuck, sum, base, hit, free_slot;
    logic [63:0] mask;
    nbytes = (mir_key_bytes < 1) ? 1 : (mir_key_bytes > 8) ? 8 : mir_key_bytes;
    nbuck = (mir_buckets < 1) ? 1 : (mir_buckets > NBUCKETS) ? NBUCKETS : mir_buckets;
    mask = (nbytes == 8) ? '1 : ((64'd1 << (nbytes * 8)) - 64'd1);
    sum = 0;
    for (int i = 0; i < nbytes; i++) sum += (i + 1) * w.key[i*8 +: 8];
    base = (sum % nbuck) * NWAYS;
    hit = -1;
    free_slot = -1;
    for (int s = base; s < base + NWAYS; s++) begin
      if (mir_valid[s]) begin
        if (hit < 0 && ((mir_key[s] ^ w.key) & mask) == 0) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    r.status = hkvt_pkg::ST_OK;
    r.value_out = '0;
    case (hkvt_pkg::action_e'(w.action))
      hkvt_pkg::ACT_INSERT: begin
        if (hit >= 0) r.status = hkvt_pkg::ST_DUPLICATE;
        else if (free_slot < 0) r.status = hkvt_pkg::ST_FULL;
        else begin
          mir_valid[free_slot] = 1'b1;
          mir_key[free_slot] = w.key;
          mir_value[free_slot] = w.value;
          mir_held++;
        end
      end
      hkvt_pkg::ACT_REMOVE, hkvt_pkg::ACT_FIND: begin
        if (hit < 0) r.status = hkvt_pkg::ST_NOT_FOUND;
        else begin
          r.value_out = mir_value[hit];
          if (w.action == hkvt_pkg::ACT_REMOVE) begin
            mir_valid[hit] = 1'b0;
            mir_held--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = mir_held[6:0];
    return r;
  endfunction

  // Offers one word, honoring the sender idle rate; valid stays high after it.
  task automatic offer_word(hkvt_pkg::in_word_t w, output hkvt_pkg::out_word_t predicted);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall);
    predicted = table_lookup(w);
  endtask

  task automatic write_reg(logic idx, logic [4:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hkvt_pkg::CFG_KEY_BYTES) mir_key_bytes = data[3:0];
    else mir_buckets = data;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Receiver: checks each result word and drives the stall.
  always @(posedge clk_i) begin
    hkvt_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word_o);
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.status !== want.status || out_word_o.value_out !== want.value_out ||
            out_word_o.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                     want.status, want.value_out, want.entry_count,
                     out_word_o.status, out_word_o.value_out, out_word_o.entry_count);
        end
      end
    end
    if (hold_request != 0 && hold_left == 0) hold_left = hold_request;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    hkvt_pkg::action_e act;
    logic [63:0]       key;
    logic [31:0]       value;
    bit                typed;
    hkvt_pkg::status_e st;
    logic [31:0]       vout;
    int                count;
  } step_row_t;

  // Directed steps under the reset settings: one key byte, sixteen buckets.
  step_row_t steps[] = '{
    '{hkvt_pkg::ACT_FIND,   64'h0,   32'h0,        1, hkvt_pkg::ST_NOT_FOUND, 32'h0, 0},
    '{hkvt_pkg::ACT_REMOVE, 64'h5,   32'h0,        1, hkvt_pkg::ST_NOT_FOUND, 32'h0, 0},
    '{hkvt_pkg::ACT_NONE,   64'h0,   32'h0,        1, hkvt_pkg::ST_OK,        32'h0, 0},
    '{hkvt_pkg::ACT_INSERT, 64'h0,   32'h7fffffff, 1, hkvt_pkg::ST_OK,        32'h0, 1},
    '{hkvt_pkg::ACT_INSERT, 64'h100, 32'h1,        1, hkvt_pkg::ST_DUPLICATE, 32'h0, 1},
    '{hkvt_pkg::ACT_FIND,   64'hffffffffffffff00, 32'h0, 1, hkvt_pkg::ST_OK,
      32'h7fffffff, 1},
    '{hkvt_pkg::ACT_INSERT, 64'h10,  32'h80000000, 1, hkvt_pkg::ST_OK,        32'h0, 2},
    '{hkvt_pkg::ACT_INSERT, 64'h20,  32'h12345678, 1, hkvt_pkg::ST_OK,        32'h0, 3},
    '{hkvt_pkg::ACT_INSERT, 64'h30,  32'h55aa55aa, 1, hkvt_pkg::ST_OK,        32'h0, 4},
    '{hkvt_pkg::ACT_INSERT, 64'h40,  32'h1,        1, hkvt_pkg::ST_FULL,      32'h0, 4},
    '{hkvt_pkg::ACT_FIND,   64'h10,  32'h0,        1, hkvt_pkg::ST_OK, 32'h80000000, 4},
    '{hkvt_pkg::ACT_REMOVE, 64'h20,  32'h0,        1, hkvt_pkg::ST_OK, 32'h12345678, 3},
    '{hkvt_pkg::ACT_INSERT, 64'h40,  32'hffffffff, 0, hkvt_pkg::ST_OK,        32'h0, 0},
    '{hkvt_pkg::ACT_FIND,   64'h40,  32'h0,        0, hkvt_pkg::ST_OK,        32'h0, 0},
    '{hkvt_pkg::ACT_REMOVE, 64'h40,  32'h0,        0, hkvt_pkg::ST_OK,        32'h0, 0},
    '{hkvt_pkg::ACT_INSERT, 64'hffffffffffffffff, 32'h0, 1, hkvt_pkg::ST_OK, 32'h0, 4},
    '{hkvt_pkg::ACT_FIND,   64'hffffffffffffffff, 32'h0, 1, hkvt_pkg::ST_OK, 32'h0, 4},
    '{hkvt_pkg::ACT_NONE,   64'hffffffffffffffff, 32'hffffffff, 1, hkvt_pkg::ST_OK,
      32'h0, 4},
    '{hkvt_pkg::ACT_REMOVE, 64'h0,   32'h0,        1, hkvt_pkg::ST_OK, 32'h7fffffff, 3},
    '{hkvt_pkg::ACT_REMOVE, 64'h10,  32'h0,        1, hkvt_pkg::ST_OK, 32'h80000000, 2},
    '{hkvt_pkg::ACT_REMOVE, 64'h30,  32'h0,        1, hkvt_pkg::ST_OK, 32'h55aa55aa, 1},
    '{hkvt_pkg::ACT_REMOVE, 64'hffffffffffffffff, 32'h0, 1, hkvt_pkg::ST_OK, 32'h0, 0}
  };

  // Settings per random phase: key bytes, bucket count.
  logic [4:0] phase_cfg[6][2] = '{'{8, 1}, '{0, 31}, '{15, 0}, '{3, 5}, '{2, 16}, '{1, 16}};

  initial begin
    hkvt_pkg::in_word_t w;
    hkvt_pkg::out_word_t r;
    int pick;
    for (int s = 0; s < NSLOTS; s++) mir_valid[s] = 1'b0;
    mir_held = 0;
    mir_key_bytes = 4'd1;
    mir_buckets = 5'd16;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (steps[i]) begin
      w.action = steps[i].act;
      w.key = steps[i].key;
      w.value = steps[i].value;
      offer_word(w, r);
      if (steps[i].typed) begin
        r.status = steps[i].st;
        r.value_out = steps[i].vout;
        r.entry_count = steps[i].count[6:0];
      end
      pending_results.push_back(r);
    end
    drain();

    // Random phases: keys mostly from a small pool so hits and full buckets occur.
    for (int p = 0; p < 6; p++) begin
      write_reg(hkvt_pkg::CFG_KEY_BYTES, phase_cfg[p][0]);
      write_reg(hkvt_pkg::CFG_BUCKET_COUNT, phase_cfg[p][1]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 85; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 85; end
        default: begin sender_idle_pct = 38; stall_pct = 38; end
      endcase
      if (p == 4) hold_request = 400;
      for (int n = 0; n < 190; n++) begin
        if (n == 1) hold_request = 0;
        pick = $urandom_range(99);
        w.action = (pick < 45) ? hkvt_pkg::ACT_INSERT : (pick < 65) ? hkvt_pkg::ACT_REMOVE :
                   (pick < 95) ? hkvt_pkg::ACT_FIND : hkvt_pkg::ACT_NONE;
        w.key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(23)]
                                        : {$urandom, $urandom};
        w.value = $urandom;
        offer_word(w, r);
        pending_results.push_back(r);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/hkvt_pkg.sv
rtl/hkvt_front.sv
rtl/hkvt_back.sv
rtl/hkvt_queue.sv
rtl/hashed_key_value_table.sv
rtl/hkvt_checker.sv
tb/tb_hashed_key_value_table.sv
